// ----- sv/krt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Package for the keyed record table: field widths, record layout, codes
// and controller states. No dependencies.
package krt_pkg;

  localparam int unsigned KeyW    = 16;
  localparam int unsigned PriceW  = 24;
  localparam int unsigned YearW   = 12;
  localparam int unsigned ColorW  = 8;
  localparam int unsigned MaxResults = 16;
  localparam int unsigned CntW    = 5;

  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic [PriceW-1:0] price;
    logic [YearW-1:0]  year;
    logic [ColorW-1:0] color;
  } rec_t;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_LOOKUP = 3'd2,
    OP_UPDATE = 3'd3,
    OP_SORT   = 3'd4,
    OP_LIST   = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    FS_KEY   = 2'd0,
    FS_PRICE = 2'd1,
    FS_YEAR  = 2'd2,
    FS_COLOR = 2'd3
  } fsel_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_FIN,
    S_SRDI,
    S_SLDI,
    S_SRDJ,
    S_SCMPJ,
    S_SIEND,
    S_LSCAN,
    S_LDAT
  } state_e;

endpackage
`default_nettype wire

// ----- sv/krt_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Request and response channel interfaces of the keyed record table.
// Depends on krt_pkg for field widths.
interface krt_req_if import krt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [2:0]        opcode;
  logic [KeyW-1:0]   lookup_key;
  logic [1:0]        field_select;
  logic [KeyW-1:0]   new_key;
  logic [PriceW-1:0] price_in;
  logic [YearW-1:0]  year_in;
  logic [ColorW-1:0] color_in;
  modport source (output valid, opcode, lookup_key, field_select, new_key, price_in,
                  year_in, color_in, input ready);
  modport sink (input valid, opcode, lookup_key, field_select, new_key, price_in,
                year_in, color_in, output ready);
endinterface

interface krt_rsp_if import krt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic [KeyW-1:0]   key_out;
  logic [PriceW-1:0] price_out;
  logic [YearW-1:0]  year_out;
  logic [ColorW-1:0] color_out;
  logic              last_out;
  modport source (output valid, status, key_out, price_out, year_out, color_out,
                  last_out, input ready);
  modport sink (input valid, status, key_out, price_out, year_out, color_out,
                last_out, output ready);
endinterface
`default_nettype wire

// ----- sv/krt_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Record store: one write port, one read port with registered data.
// Depends on krt_pkg for the record layout.
module krt_mem import krt_pkg::*; #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  rec_t                  wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output rec_t                  rdata_o
);

  rec_t mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ----- sv/keyed_record_table.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Keyed record table: TABLE_DEPTH records in a synchronous memory with valid
// flags in flip-flops, cleared at reset. Insert, delete, lookup and update
// scan the memory one slot per cycle; sort is an exchange sort by key through
// the one read port and one write port of the memory; list steps past empty
// slots and returns each valid record in slot order, up to MaxResults records
// per request. One request is worked at a time; the result register lets the
// next request in while a result waits.
module keyed_record_table import krt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  krt_req_if.sink    in_i,
  krt_rsp_if.source  out_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [AW-1:0] LastIdx = AW'(TABLE_DEPTH - 1);
  localparam logic [AW-1:0] LastI   = AW'(TABLE_DEPTH - 2);
  localparam logic [CW-1:0] DepthC  = CW'(TABLE_DEPTH);
  localparam logic [CntW-1:0] LastN = CntW'(MaxResults - 1);

  state_e state_q, state_d;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;

  op_e               op_q, op_d;
  logic [KeyW-1:0]   key_q, key_d, nkey_q, nkey_d;
  logic [1:0]        fsel_q, fsel_d;
  logic [PriceW-1:0] price_q, price_d;
  logic [YearW-1:0]  year_q, year_d;
  logic [ColorW-1:0] color_q, color_d;

  logic [CW-1:0]   rd_q, rd_d, li_q, li_d;
  logic            dv_q, dv_d, hit_q, hit_d, full_q, full_d, curv_q, curv_d;
  logic [AW-1:0]   ca_q, ca_d, hidx_q, hidx_d, free_q, free_d, i_q, i_d, j_q, j_d;
  rec_t            hrec_q, hrec_d, cur_q, cur_d;
  logic [CntW-1:0] n_q, n_d;

  logic            out_valid_q, out_valid_d, out_last_q, out_last_d;
  status_e         out_status_q, out_status_d;
  rec_t            out_rec_q, out_rec_d;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  rec_t            mem_wdata, mem_rdata, new_rec, mod_rec;

  logic            out_free, load, more, swap;
  logic [AW-1:0]   free_idx;

  krt_mem #(.Depth(TABLE_DEPTH), .AddrW(AW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE);

  always_comb begin
    free_idx = '0;
    for (int k = TABLE_DEPTH - 1; k >= 0; k--) begin
      if (!valid_q[k]) begin
        free_idx = AW'(k);
      end
    end
  end

  always_comb begin
    more = 1'b0;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      if (valid_q[k] && (CW'(k) > li_q)) begin
        more = 1'b1;
      end
    end
  end

  assign new_rec = '{key: key_q, price: price_q, year: year_q, color: color_q};

  always_comb begin
    mod_rec = hrec_q;
    unique case (fsel_e'(fsel_q))
      FS_KEY:   mod_rec.key   = nkey_q;
      FS_PRICE: mod_rec.price = price_q;
      FS_YEAR:  mod_rec.year  = year_q;
      FS_COLOR: mod_rec.color = color_q;
      default:  mod_rec = hrec_q;
    endcase
  end

  assign swap = valid_q[j_q] && (!curv_q || (cur_q.key > mem_rdata.key));

  always_comb begin
    state_d = state_q;
    valid_d = valid_q;
    op_d = op_q; key_d = key_q; nkey_d = nkey_q; fsel_d = fsel_q;
    price_d = price_q; year_d = year_q; color_d = color_q;
    rd_d = rd_q; li_d = li_q; dv_d = 1'b0; hit_d = hit_q; full_d = full_q;
    curv_d = curv_q; ca_d = ca_q; hidx_d = hidx_q; free_d = free_q;
    i_d = i_q; j_d = j_q; hrec_d = hrec_q; cur_d = cur_q; n_d = n_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_last_d = out_last_q; out_status_d = out_status_q; out_rec_d = out_rec_q;
    mem_we = 1'b0; mem_waddr = '0; mem_wdata = cur_q; mem_raddr = '0;
    load = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          op_d = op_e'(in_i.opcode);
          key_d = in_i.lookup_key; nkey_d = in_i.new_key; fsel_d = in_i.field_select;
          price_d = in_i.price_in; year_d = in_i.year_in; color_d = in_i.color_in;
          rd_d = '0; hit_d = 1'b0;
          full_d = &valid_q; free_d = free_idx;
          i_d = '0; li_d = '0; n_d = '0;
          case (in_i.opcode)
            OP_INSERT: state_d = (&valid_q) ? S_FIN : S_SCAN;
            OP_DELETE, OP_LOOKUP, OP_UPDATE: state_d = S_SCAN;
            OP_SORT: state_d = S_SRDI;
            OP_LIST: state_d = (|valid_q) ? S_LSCAN : S_FIN;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        mem_raddr = rd_q[AW-1:0];
        if (rd_q < DepthC) begin
          dv_d = 1'b1; ca_d = rd_q[AW-1:0]; rd_d = rd_q + 1'b1;
        end
        if (dv_q && valid_q[ca_q] && (mem_rdata.key == key_q)) begin
          hit_d = 1'b1; hidx_d = ca_q; hrec_d = mem_rdata; state_d = S_FIN;
        end else if (dv_q && (ca_q == LastIdx)) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          load = 1'b1; out_last_d = 1'b1; out_rec_d = '0; out_status_d = ST_OK;
          case (op_q)
            OP_INSERT: begin
              if (full_q) begin
                out_status_d = ST_FULL;
              end else if (hit_q) begin
                out_status_d = ST_DUPLICATE; out_rec_d = hrec_q;
              end else begin
                mem_we = 1'b1; mem_waddr = free_q; mem_wdata = new_rec;
                valid_d[free_q] = 1'b1; out_rec_d = new_rec;
              end
            end
            OP_DELETE, OP_LOOKUP, OP_UPDATE: begin
              if (!hit_q) begin
                out_status_d = ST_NOT_FOUND;
              end else if (op_q == OP_DELETE) begin
                valid_d[hidx_q] = 1'b0; out_rec_d = hrec_q;
              end else if (op_q == OP_UPDATE) begin
                mem_we = 1'b1; mem_waddr = hidx_q; mem_wdata = mod_rec;
                out_rec_d = mod_rec;
              end else begin
                out_rec_d = hrec_q;
              end
            end
            OP_LIST: out_status_d = ST_EMPTY;
            default: out_status_d = ST_OK;
          endcase
          state_d = S_IDLE;
        end
      end
      S_SRDI: begin
        mem_raddr = i_q;
        state_d = S_SLDI;
      end
      S_SLDI: begin
        cur_d = mem_rdata; curv_d = valid_q[i_q];
        j_d = i_q + 1'b1;
        state_d = S_SRDJ;
      end
      S_SRDJ: begin
        mem_raddr = j_q;
        state_d = S_SCMPJ;
      end
      S_SCMPJ: begin
        if (swap) begin
          mem_we = 1'b1; mem_waddr = j_q; mem_wdata = cur_q;
          valid_d[j_q] = curv_q;
          cur_d = mem_rdata; curv_d = valid_q[j_q];
        end
        if (j_q == LastIdx) begin
          state_d = S_SIEND;
        end else begin
          j_d = j_q + 1'b1; state_d = S_SRDJ;
        end
      end
      S_SIEND: begin
        mem_we = 1'b1; mem_waddr = i_q; mem_wdata = cur_q;
        valid_d[i_q] = curv_q;
        if (i_q == LastI) begin
          state_d = S_FIN;
        end else begin
          i_d = i_q + 1'b1; state_d = S_SRDI;
        end
      end
      S_LSCAN: begin
        mem_raddr = li_q[AW-1:0];
        if (li_q >= DepthC) begin
          state_d = S_IDLE;
        end else if (valid_q[li_q[AW-1:0]]) begin
          state_d = S_LDAT;
        end else begin
          li_d = li_q + 1'b1;
        end
      end
      S_LDAT: begin
        mem_raddr = li_q[AW-1:0];
        if (out_free) begin
          load = 1'b1; out_status_d = ST_OK; out_rec_d = mem_rdata;
          out_last_d = (n_q == LastN) || !more;
          n_d = n_q + 1'b1; li_d = li_q + 1'b1;
          state_d = ((n_q == LastN) || !more) ? S_IDLE : S_LSCAN;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      out_valid_q <= 1'b0;
      dv_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      out_valid_q <= out_valid_d;
      dv_q <= dv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; key_q <= key_d; nkey_q <= nkey_d; fsel_q <= fsel_d;
    price_q <= price_d; year_q <= year_d; color_q <= color_d;
    rd_q <= rd_d; li_q <= li_d; hit_q <= hit_d; full_q <= full_d; curv_q <= curv_d;
    ca_q <= ca_d; hidx_q <= hidx_d; free_q <= free_d; i_q <= i_d; j_q <= j_d;
    hrec_q <= hrec_d; cur_q <= cur_d; n_q <= n_d;
    out_last_q <= out_last_d; out_status_q <= out_status_d; out_rec_q <= out_rec_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.status    = out_status_q;
  assign out_o.key_out   = out_rec_q.key;
  assign out_o.price_out = out_rec_q.price;
  assign out_o.year_out  = out_rec_q.year;
  assign out_o.color_out = out_rec_q.color;
  assign out_o.last_out  = out_last_q;

`ifndef SYNTHESIS
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (rd_q <= DepthC))
    else $error("scan address past table end");

  a_valid_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q != $past(valid_q)) |-> ($past(state_q) == S_FIN ||
      $past(state_q) == S_SCMPJ || $past(state_q) == S_SIEND))
    else $error("valid flags changed outside a write step");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && out_valid_q) |-> out_o.ready)
    else $error("result register overwritten before taken");
`endif

endmodule
`default_nettype wire
